// ----- src/wlm_pkg.sv -----
package wlm_pkg;

	localparam int DEF_MAX_ROWS   = 1024;
	localparam int DEF_MAX_COLS   = 1024;
	localparam int DEF_MAX_HALF   = 7;
	localparam int DEF_PIXEL_BITS = 16;

	// configuration port
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int HALF_REG_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_HALF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd2;

	// result position fields
	localparam int ROW_W = 10;
	localparam int COL_W = 10;

endpackage

// ----- src/wlm_reduce.sv -----
module wlm_reduce #(
	parameter int N  = 15,
	parameter int PW = 16,
	parameter int CW = 4
) (
	input  logic                 clk,
	input  logic                 in_v [N],
	input  logic signed [PW-1:0] in_m [N],
	input  logic        [CW-1:0] in_c [N],
	output logic                 out_v,
	output logic signed [PW-1:0] out_m,
	output logic        [CW-1:0] out_c
);

	localparam int G  = 4;
	localparam int NG = (N + G - 1) / G;

	typedef struct packed {
		logic                 v;
		logic signed [PW-1:0] m;
		logic        [CW-1:0] c;
	} elem_t;

	// keep the larger maximum; on a tie add the occurrence counts
	function automatic elem_t merge(elem_t a, elem_t b);
		elem_t r;
		r = a;
		if (!a.v) begin
			r = b;
		end else if (b.v) begin
			if (b.m > a.m) begin
				r = b;
			end else if (b.m == a.m) begin
				r.c = a.c + b.c;
			end
		end
		return r;
	endfunction

	elem_t pad [NG*G];
	elem_t part_d [NG];
	elem_t part_s1 [NG];
	elem_t res_d;
	elem_t res_s2;

	for (genvar i = 0; i < NG*G; i++) begin : g_pad
		if (i < N) begin : g_in
			assign pad[i] = elem_t'{v: in_v[i], m: in_m[i], c: in_c[i]};
		end else begin : g_fill
			assign pad[i] = '0;
		end
	end

	always_comb begin
		elem_t acc;
		for (int g = 0; g < NG; g++) begin
			acc = pad[g*G];
			for (int j = 1; j < G; j++) begin
				acc = merge(acc, pad[g*G+j]);
			end
			part_d[g] = acc;
		end
	end

	always_ff @(posedge clk) begin
		part_s1 <= part_d;
	end

	always_comb begin
		res_d = part_s1[0];
		for (int g = 1; g < NG; g++) begin
			res_d = merge(res_d, part_s1[g]);
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= res_d;
	end

	assign out_v = res_s2.v;
	assign out_m = res_s2.m;
	assign out_c = res_s2.c;

endmodule

// ----- src/window_local_maximum_unit.sv -----
// Sliding-window local maximum over a streamed image.
// Input: s_tvalid/s_tready/s_tdata carry one signed pixel per transfer, column-major
// (row index fastest). Output: one transfer per interior window centre with its row,
// column, the pixel value when it is the unique window maximum (else zero), tuser set
// for a peak and tlast on the last centre of the frame. Border pixels give no output.
// Configuration: cfg_we/cfg_index/cfg_data write half width, rows or cols; a write to any
// of them restarts the frame. Write only while the block is idle.
// Pipeline: each input transfer passes registers s1 to s5 and then the output queue.
// Throughput: one pixel per cycle while s_tready is high. Each pixel does one read and one write of the
// per-row history memory (one entry per image row holding the column summaries of the
// last 2*MAX_HALF columns), and two pipelined max/count trees (vertical, horizontal).
// An 8-entry output queue holds results; s_tready drops once 8 results are in flight or
// queued, so a stalled receiver stops input after at most 8 outstanding results.
// Reset clears counters, pipeline and queue and restores half width 1 and a 1024 x 1024
// frame; the history memory needs no clearing since each entry is written before use.
module window_local_maximum_unit import wlm_pkg::*; #(
	parameter int MAX_ROWS   = DEF_MAX_ROWS,
	parameter int MAX_COLS   = DEF_MAX_COLS,
	parameter int MAX_HALF   = DEF_MAX_HALF,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             s_tvalid,
	output logic                                             s_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0]                  s_tdata, // pixel
	output logic                                             m_tvalid,
	input  logic                                             m_tready,
	output logic [((ROW_W+COL_W+PIXEL_BITS+7)/8)*8-1:0]      m_tdata, // row, col, value
	output logic                                             m_tuser, // is_peak
	output logic                                             m_tlast,
	input  logic                                             cfg_we,
	input  logic [CFG_IDX_W-1:0]                             cfg_index,
	input  logic [CFG_W-1:0]                                 cfg_data
);

	localparam int OW   = ((ROW_W + COL_W + PIXEL_BITS + 7) / 8) * 8;
	localparam int RCW  = $clog2(MAX_ROWS);
	localparam int CCW  = $clog2(MAX_COLS);
	localparam int NRW  = $clog2(MAX_ROWS + 1);
	localparam int NCW  = $clog2(MAX_COLS + 1);
	localparam int BW   = $clog2(MAX_HALF + 1);
	localparam int NT   = 2 * MAX_HALF + 1;
	localparam int TW   = $clog2(NT);
	localparam int NS   = 2 * MAX_HALF;
	localparam int SIW  = $clog2(NS);
	localparam int VCW  = $clog2(NT + 1);
	localparam int HCW  = $clog2(NT * NT + 1);
	localparam int SW   = 2 * PIXEL_BITS + VCW;
	localparam int HW   = NS * SW;
	localparam int PAY  = ROW_W + COL_W + PIXEL_BITS;
	localparam int OD   = 8;
	localparam int OPW  = $clog2(OD);
	localparam int OCW  = $clog2(OD + 1);
	localparam int RST_ROWS = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
	localparam int RST_COLS = (MAX_COLS < 1024) ? MAX_COLS : 1024;

	// configuration
	logic [BW-1:0]  b_q;
	logic [NRW-1:0] nr_q;
	logic [NCW-1:0] nc_q;
	logic [BW-1:0]  half_sat;
	logic [NRW-1:0] rows_sat;
	logic [NCW-1:0] cols_sat;
	logic           cfg_hit;

	// scan position
	logic [RCW-1:0] r_q;
	logic [CCW-1:0] c_q;
	logic           accept;
	logic           emit0;
	logic           last0;
	logic           row_wrap;
	logic           col_wrap;
	logic [ROW_W-1:0] cy0;
	logic [COL_W-1:0] cx0;
	logic signed [PIXEL_BITS-1:0] pixel;

	logic signed [PIXEL_BITS-1:0] vline_q [NT];

	// pipeline
	logic v_s1, v_s2, v_s3;
	logic em_s1, em_s2, em_s3, em_s4, em_s5;
	logic l_s1, l_s2, l_s3, l_s4, l_s5;
	logic [RCW-1:0] row_s1, row_s2, row_s3;
	logic [ROW_W-1:0] cy_s1, cy_s2, cy_s3, cy_s4, cy_s5;
	logic [COL_W-1:0] cx_s1, cx_s2, cx_s3, cx_s4, cx_s5;
	logic signed [PIXEL_BITS-1:0] mid_s2, mid_s3;
	logic signed [PIXEL_BITS-1:0] centre_s4, centre_s5;
	logic [HW-1:0] hist_mem [MAX_ROWS];
	logic [HW-1:0] hrd_s1, bypd_s1, hist_s1, hist_s2, hist_s3;
	logic          byp_s1;
	logic [HW-1:0] hwr_s3;
	logic [SW-1:0] vslot;
	logic signed [PIXEL_BITS-1:0] slot_mid [NS];

	// reductions
	logic                         vin_v [NT];
	logic signed [PIXEL_BITS-1:0] vin_m [NT];
	logic        [VCW-1:0]        vin_c [NT];
	logic                         vr_v;
	logic signed [PIXEL_BITS-1:0] vr_m;
	logic        [VCW-1:0]        vr_c;
	logic                         hin_v [NT];
	logic signed [PIXEL_BITS-1:0] hin_m [NT];
	logic        [HCW-1:0]        hin_c [NT];
	logic                         hr_v;
	logic signed [PIXEL_BITS-1:0] hr_m;
	logic        [HCW-1:0]        hr_c;
	logic                         peak_s5;

	// output queue
	logic [PAY-1:0] q_data [OD];
	logic           q_peak [OD];
	logic           q_last [OD];
	logic [OPW-1:0] wp_q, rp_q;
	logic [OCW-1:0] cnt_q, used_q;
	logic           push, pop;

	// ---------------- configuration ----------------
	always_comb begin
		if (32'(cfg_data[HALF_REG_W-1:0]) > 32'(MAX_HALF)) begin
			half_sat = BW'(MAX_HALF);
		end else begin
			half_sat = BW'(cfg_data[HALF_REG_W-1:0]);
		end
		if (cfg_data == '0) begin
			rows_sat = NRW'(1);
			cols_sat = NCW'(1);
		end else begin
			rows_sat = (32'(cfg_data) > 32'(MAX_ROWS)) ? NRW'(MAX_ROWS) : NRW'(cfg_data);
			cols_sat = (32'(cfg_data) > 32'(MAX_COLS)) ? NCW'(MAX_COLS) : NCW'(cfg_data);
		end
	end

	assign cfg_hit = cfg_we && (cfg_index == REG_HALF || cfg_index == REG_ROWS
		|| cfg_index == REG_COLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q  <= BW'(1);
			nr_q <= NRW'(RST_ROWS);
			nc_q <= NCW'(RST_COLS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HALF: b_q  <= half_sat;
				REG_ROWS: nr_q <= rows_sat;
				REG_COLS: nc_q <= cols_sat;
				default: ;
			endcase
		end
	end

	// ---------------- scan position ----------------
	assign accept   = s_tvalid && s_tready;
	assign pixel    = s_tdata[PIXEL_BITS-1:0];
	assign row_wrap = (NRW'(r_q) + NRW'(1)) >= nr_q;
	assign col_wrap = (NCW'(c_q) + NCW'(1)) >= nc_q;
	assign emit0    = (32'(r_q) >= 32'({b_q, 1'b0})) && (32'(c_q) >= 32'({b_q, 1'b0}));
	assign last0    = ((NRW'(r_q) + NRW'(1)) == nr_q) && ((NCW'(c_q) + NCW'(1)) == nc_q);
	assign cy0      = ROW_W'(32'(r_q) - 32'(b_q));
	assign cx0      = COL_W'(32'(c_q) - 32'(b_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
		end else if (cfg_hit) begin
			r_q <= '0;
			c_q <= '0;
		end else if (accept) begin
			if (row_wrap) begin
				r_q <= '0;
				c_q <= col_wrap ? '0 : c_q + CCW'(1);
			end else begin
				r_q <= r_q + RCW'(1);
			end
		end
	end

	// vertical shift line: tap k holds the pixel k rows above the newest
	always_ff @(posedge clk) begin
		if (accept) begin
			vline_q[0] <= pixel;
			for (int k = 1; k < NT; k++) begin
				vline_q[k] <= vline_q[k-1];
			end
		end
	end

	// ---------------- pipeline control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			em_s1 <= 1'b0;
			em_s2 <= 1'b0;
			em_s3 <= 1'b0;
			em_s4 <= 1'b0;
			em_s5 <= 1'b0;
		end else begin
			v_s1  <= accept;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			em_s1 <= accept && emit0;
			em_s2 <= em_s1;
			em_s3 <= em_s2;
			em_s4 <= em_s3;
			em_s5 <= em_s4;
		end
	end

	always_ff @(posedge clk) begin
		l_s1      <= last0;
		row_s1    <= r_q;
		cy_s1     <= cy0;
		cx_s1     <= cx0;
		l_s2      <= l_s1;
		row_s2    <= row_s1;
		cy_s2     <= cy_s1;
		cx_s2     <= cx_s1;
		mid_s2    <= vline_q[TW'(b_q)];
		hist_s2   <= hist_s1;
		l_s3      <= l_s2;
		row_s3    <= row_s2;
		cy_s3     <= cy_s2;
		cx_s3     <= cx_s2;
		mid_s3    <= mid_s2;
		hist_s3   <= hist_s2;
		l_s4      <= l_s3;
		cy_s4     <= cy_s3;
		cx_s4     <= cx_s3;
		centre_s4 <= (b_q == '0) ? mid_s3 : slot_mid[SIW'(b_q - BW'(1))];
		l_s5      <= l_s4;
		cy_s5     <= cy_s4;
		cx_s5     <= cx_s4;
		centre_s5 <= centre_s4;
	end

	// ---------------- history memory ----------------
	// Read at the row of the incoming pixel into s1, write back the shifted word from s3;
	// forward the write when it lands on the row being read in the same cycle.
	always_ff @(posedge clk) begin
		hrd_s1  <= hist_mem[r_q];
		byp_s1  <= v_s3 && (row_s3 == r_q);
		bypd_s1 <= hwr_s3;
		if (v_s3) begin
			hist_mem[row_s3] <= hwr_s3;
		end
	end

	assign hist_s1 = byp_s1 ? bypd_s1 : hrd_s1;
	assign vslot   = {mid_s3, vr_c, vr_m};
	assign hwr_s3  = {hist_s3[(NS-1)*SW-1:0], vslot};

	// ---------------- vertical max/count ----------------
	for (genvar k = 0; k < NT; k++) begin : g_vin
		assign vin_v[k] = (32'(k) <= 32'({b_q, 1'b0}));
		assign vin_m[k] = vline_q[k];
		assign vin_c[k] = VCW'(1);
	end

	wlm_reduce #(.N(NT), .PW(PIXEL_BITS), .CW(VCW)) u_vert (
		.clk   (clk),
		.in_v  (vin_v),
		.in_m  (vin_m),
		.in_c  (vin_c),
		.out_v (vr_v),
		.out_m (vr_m),
		.out_c (vr_c)
	);

	// ---------------- horizontal max/count ----------------
	assign hin_v[0] = vr_v;
	assign hin_m[0] = vr_m;
	assign hin_c[0] = HCW'(vr_c);

	for (genvar k = 1; k < NT; k++) begin : g_hin
		assign hin_v[k]      = (32'(k) <= 32'({b_q, 1'b0}));
		assign hin_m[k]      = hist_s3[(k-1)*SW +: PIXEL_BITS];
		assign hin_c[k]      = HCW'(hist_s3[(k-1)*SW+PIXEL_BITS +: VCW]);
		assign slot_mid[k-1] = hist_s3[(k-1)*SW+PIXEL_BITS+VCW +: PIXEL_BITS];
	end

	wlm_reduce #(.N(NT), .PW(PIXEL_BITS), .CW(HCW)) u_horz (
		.clk   (clk),
		.in_v  (hin_v),
		.in_m  (hin_m),
		.in_c  (hin_c),
		.out_v (hr_v),
		.out_m (hr_m),
		.out_c (hr_c)
	);

	assign peak_s5 = hr_v && (hr_c == HCW'(1)) && (hr_m == centre_s5);

	// ---------------- output queue ----------------
	assign push     = em_s5;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = OW'(q_data[rp_q]);
	assign m_tuser  = q_peak[rp_q];
	assign m_tlast  = q_last[rp_q];
	assign s_tready = (used_q < OCW'(OD));

	always_ff @(posedge clk) begin
		if (push) begin
			q_data[wp_q] <= {peak_s5 ? centre_s5 : PIXEL_BITS'(0), cx_s5, cy_s5};
			q_peak[wp_q] <= peak_s5;
			q_last[wp_q] <= l_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			cnt_q  <= '0;
			used_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + OPW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + OPW'(1);
			end
			cnt_q  <= cnt_q + OCW'(push) - OCW'(pop);
			// hold a slot for every result still in the pipeline
			used_q <= used_q + OCW'(accept && emit0) - OCW'(pop);
		end
	end

endmodule

// ----- src/wlm_check.sv -----
module wlm_check import wlm_pkg::*; #(
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input logic                                        clk,
	input logic                                        arst_n,
	input logic                                        m_tvalid,
	input logic                                        m_tready,
	input logic [((ROW_W+COL_W+PIXEL_BITS+7)/8)*8-1:0] m_tdata,
	input logic                                        m_tuser,
	input logic                                        m_tlast,
	input logic                                        cfg_we,
	input logic [CFG_IDX_W-1:0]                        cfg_index,
	input logic [CFG_W-1:0]                            cfg_data
);

	logic             xfer;
	logic             prev_ok_q;
	logic             prev_peak_q;
	logic             wide_q;
	logic [ROW_W-1:0] prev_row_q;
	logic [COL_W-1:0] prev_col_q;
	logic [ROW_W-1:0] cur_row;
	logic [COL_W-1:0] cur_col;

	assign xfer    = m_tvalid && m_tready;
	assign cur_row = m_tdata[ROW_W-1:0];
	assign cur_col = m_tdata[ROW_W +: COL_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ok_q <= 1'b0;
			wide_q    <= 1'b1;
		end else if (cfg_we && (cfg_index == REG_HALF || cfg_index == REG_ROWS
				|| cfg_index == REG_COLS)) begin
			prev_ok_q <= 1'b0;
			if (cfg_index == REG_HALF) begin
				wide_q <= (cfg_data[HALF_REG_W-1:0] != '0);
			end
		end else if (xfer) begin
			prev_ok_q <= !m_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			prev_peak_q <= m_tuser;
			prev_row_q  <= cur_row;
			prev_col_q  <= cur_col;
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[ROW_W+COL_W +: PIXEL_BITS] == '0)
		else $error("non-peak result carries a value");

	// vertically adjacent centres lie in each other's window: both cannot be unique maxima
	a_adjacent_peaks: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && m_tuser && prev_ok_q && prev_peak_q && wide_q && cur_col == prev_col_q
		|-> cur_row != prev_row_q + ROW_W'(1))
		else $error("two adjacent peaks in one column");

endmodule

bind window_local_maximum_unit wlm_check #(.PIXEL_BITS(PIXEL_BITS)) u_wlm_check (.*);
